// ----- rtl/qntg_pkg.sv -----
// Shared types and constants for the quad normal/tangent generator.
// No dependencies; imported by the interfaces and all modules.
package qntg_pkg;

    // packed field widths
    localparam int POS_W    = 21;         // one signed position component
    localparam int POS_PK_W = 3 * POS_W;  // packed xyz position
    localparam int UV_W     = 64;         // packed u/v pair
    localparam int UVC_W    = 32;         // one signed uv component
    localparam int UNIT_W   = 16;         // one unit-vector component
    localparam int UNIT_PK_W = 3 * UNIT_W;

    // normalizer internals
    localparam int LANE_W = 56;           // signed input width of a normalizer lane
    localparam int M_W    = 30;           // magnitude width after pre-scaling
    localparam int SQ_ST  = 32;           // square-root stages, one result bit each
    localparam logic [UNIT_W-1:0] UNIT_CAP = 16'd32767;

    // vertex sequencer
    localparam logic [2:0] VERT_FIRST = 3'd0;
    localparam logic [2:0] TRI_SPLIT  = 3'd3;
    localparam logic [2:0] VERT_LAST  = 3'd5;

    typedef logic [POS_PK_W-1:0]  t_pos;
    typedef logic [UV_W-1:0]      t_uv;
    typedef logic [UNIT_PK_W-1:0] t_unit;

endpackage

// ----- rtl/qntg_quad_if.sv -----
// Input channel carrying one textured quad per transfer.
// Depends on qntg_pkg.
interface qntg_quad_if;
    import qntg_pkg::*;

    logic valid;
    logic ready;
    t_pos pos_bottom_left;
    t_pos pos_bottom_right;
    t_pos pos_top_left;
    t_pos pos_top_right;
    t_uv  uv_bottom_left;
    t_uv  uv_bottom_right;
    t_uv  uv_top_left;
    t_uv  uv_top_right;

    modport source (
        output valid, pos_bottom_left, pos_bottom_right, pos_top_left, pos_top_right,
        output uv_bottom_left, uv_bottom_right, uv_top_left, uv_top_right,
        input  ready
    );
    modport sink (
        input  valid, pos_bottom_left, pos_bottom_right, pos_top_left, pos_top_right,
        input  uv_bottom_left, uv_bottom_right, uv_top_left, uv_top_right,
        output ready
    );
endinterface

// ----- rtl/qntg_vertex_if.sv -----
// Output channel carrying one finished vertex per transfer.
// Depends on qntg_pkg.
interface qntg_vertex_if;
    import qntg_pkg::*;

    logic  valid;
    logic  ready;
    t_pos  vertex_position;
    t_unit vertex_normal;
    t_uv   vertex_uv;
    t_unit tangent_direction;
    logic  tangent_sign;
    logic  uv_degenerate;
    logic  last_vertex;

    modport source (
        output valid, vertex_position, vertex_normal, vertex_uv, tangent_direction,
        output tangent_sign, uv_degenerate, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, vertex_position, vertex_normal, vertex_uv, tangent_direction,
        input  tangent_sign, uv_degenerate, last_vertex,
        output ready
    );
endinterface

// ----- rtl/qntg_unitize.sv -----
// Pipelined vector normalizer: pre-scale, sum of squares, bit-per-stage
// square root and bit-per-stage rounding division. Depends on qntg_pkg.
module qntg_unitize #(
    parameter int LANES  = 1,
    parameter int IN_W   = 56,
    parameter int FRAC   = 14,
    parameter int SIDE_W = 1
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  logic [LANES-1:0][2:0][IN_W-1:0]             i_vec,
    input  logic [SIDE_W-1:0]                           i_side,
    output logic o_valid,
    output logic [LANES-1:0][2:0][qntg_pkg::UNIT_W-1:0] o_vec,
    output logic [SIDE_W-1:0]                           o_side
);
    import qntg_pkg::*;

    localparam int QB   = FRAC + 1;          // quotient bits, quotient <= 2^FRAC
    localparam int DW   = M_W + FRAC + 2;    // dividend / remainder width
    localparam int SH_W = $clog2(IN_W);
    localparam int LAT  = 6 + SQ_ST + QB;

    // stage 1: sign and magnitude
    logic [LANES-1:0][2:0]           r_neg1;
    logic [LANES-1:0][2:0][IN_W-1:0] r_mag1;
    // stage 2: pre-scaled magnitudes
    logic [LANES-1:0][2:0][M_W-1:0]  n_m2, r_m2;
    logic [LANES-1:0][2:0]           r_neg2;
    // stage 3: squares
    logic [LANES-1:0][2:0][2*M_W-1:0] r_sq3;
    logic [LANES-1:0][2:0][M_W-1:0]   r_m3;
    logic [LANES-1:0][2:0]            r_neg3;
    // square root stages
    logic [LANES-1:0][63:0]          r_sv [SQ_ST+1];
    logic [LANES-1:0][63:0]          r_sr [SQ_ST+1];
    logic [LANES-1:0][2:0][M_W-1:0]  r_sm [SQ_ST+1];
    logic [LANES-1:0][2:0]           r_sn [SQ_ST+1];
    // division stages
    logic [LANES-1:0][2:0][DW-1:0]   r_dr [QB+1];
    logic [LANES-1:0][2:0][QB-1:0]   r_dq [QB+1];
    logic [LANES-1:0][31:0]          r_dl [QB+1];
    logic [LANES-1:0][2:0]           r_dn [QB+1];
    // result
    logic [LANES-1:0][2:0][UNIT_W-1:0] n_out, r_out;
    // valid and sideband delay line
    logic [LAT-1:0]    r_vld;
    logic [SIDE_W-1:0] r_side [LAT];

    // stage 1: absolute values
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                for (int c = 0; c < 3; c++) begin
                    r_neg1[l][c] <= i_vec[l][c][IN_W-1];
                    r_mag1[l][c] <= i_vec[l][c][IN_W-1] ? (~i_vec[l][c] + 1'b1)
                                                        : i_vec[l][c];
                end
            end
        end
    end

    // stage 2: halve all components together until the largest is below 2^30
    always_comb begin
        logic [IN_W-1:0] orv;
        logic [SH_W-1:0] sh;
        n_m2 = '0;
        for (int l = 0; l < LANES; l++) begin
            orv = r_mag1[l][0] | r_mag1[l][1] | r_mag1[l][2];
            sh  = '0;
            for (int b = M_W; b < IN_W; b++) begin
                if (orv[b]) sh = SH_W'(b - M_W + 1);
            end
            for (int c = 0; c < 3; c++) begin
                n_m2[l][c] = M_W'(r_mag1[l][c] >> sh);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m2   <= n_m2;
            r_neg2 <= r_neg1;
        end
    end

    // stage 3: squares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                for (int c = 0; c < 3; c++) begin
                    r_sq3[l][c] <= r_m2[l][c] * r_m2[l][c];
                end
            end
            r_m3   <= r_m2;
            r_neg3 <= r_neg2;
        end
    end

    // stage 4: sum of squares, root accumulator cleared
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_sv[0][l] <= 64'(r_sq3[l][0]) + 64'(r_sq3[l][1]) + 64'(r_sq3[l][2]);
            end
            r_sr[0] <= '0;
            r_sm[0] <= r_m3;
            r_sn[0] <= r_neg3;
        end
    end

    // integer square root, one result bit per stage
    for (genvar g = 0; g < SQ_ST; g++) begin : g_sqrt
        logic [LANES-1:0][63:0] n_v, n_r;
        always_comb begin
            logic [63:0] t;
            n_v = r_sv[g];
            n_r = r_sr[g];
            for (int l = 0; l < LANES; l++) begin
                t = r_sr[g][l] + (64'd1 << (62 - 2 * g));
                if (r_sv[g][l] >= t) begin
                    n_v[l] = r_sv[g][l] - t;
                    n_r[l] = (r_sr[g][l] >> 1) + (64'd1 << (62 - 2 * g));
                end else begin
                    n_r[l] = r_sr[g][l] >> 1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sv[g+1] <= n_v;
                r_sr[g+1] <= n_r;
                r_sm[g+1] <= r_sm[g];
                r_sn[g+1] <= r_sn[g];
            end
        end
    end

    // rounding dividend: mag * 2^FRAC + len / 2
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                for (int c = 0; c < 3; c++) begin
                    r_dr[0][l][c] <= (DW'(r_sm[SQ_ST][l][c]) << FRAC)
                                   + DW'(r_sr[SQ_ST][l][31:1]);
                end
                r_dl[0][l] <= r_sr[SQ_ST][l][31:0];
            end
            r_dq[0] <= '0;
            r_dn[0] <= r_sn[SQ_ST];
        end
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar g = 0; g < QB; g++) begin : g_div
        logic [LANES-1:0][2:0][DW-1:0] n_r;
        logic [LANES-1:0][2:0][QB-1:0] n_q;
        always_comb begin
            logic [DW-1:0] t;
            n_r = r_dr[g];
            n_q = r_dq[g];
            for (int l = 0; l < LANES; l++) begin
                t = DW'(r_dl[g][l]) << (FRAC - g);
                for (int c = 0; c < 3; c++) begin
                    if (r_dr[g][l][c] >= t) begin
                        n_r[l][c] = r_dr[g][l][c] - t;
                        n_q[l][c][FRAC-g] = 1'b1;
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dr[g+1] <= n_r;
                r_dq[g+1] <= n_q;
                r_dl[g+1] <= r_dl[g];
                r_dn[g+1] <= r_dn[g];
            end
        end
    end

    // zero length gives zero, cap, restore sign
    always_comb begin
        logic [UNIT_W-1:0] qq;
        n_out = '0;
        for (int l = 0; l < LANES; l++) begin
            for (int c = 0; c < 3; c++) begin
                if (r_dl[QB][l] == 32'd0) begin
                    qq = '0;
                end else if (17'(r_dq[QB][l][c]) > 17'(UNIT_CAP)) begin
                    qq = UNIT_CAP;
                end else begin
                    qq = UNIT_W'(r_dq[QB][l][c]);
                end
                n_out[l][c] = r_dn[QB][l][c] ? (~qq + 1'b1) : qq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    // valid bits and sideband follow the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int i = 1; i < LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_side  = r_side[LAT-1];
    assign o_vec   = r_out;

endmodule

// ----- rtl/quad_normal_tangent_generator.sv -----
// Quad normal/tangent generator. Each accepted quad yields six vertices,
// one per cycle while the output is not stalled: triangle bottom-left,
// bottom-right, top-left, then bottom-right, top-right, top-left. A new quad
// is taken on the cycle the sixth vertex of the previous one issues, so the
// vertex sequencer keeps issuing vertices with no gap between quads. Most of
// the pipeline depth lies in the two normalizers (32-stage square root,
// UNIT_FRAC_BITS+1 stage divider). The whole pipeline holds when a finished
// vertex is not taken.
// Depends on qntg_pkg, qntg_quad_if, qntg_vertex_if and qntg_unitize.
module quad_normal_tangent_generator #(
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic i_clk,
    input  logic i_rst_n,
    qntg_quad_if.sink     i_quad,
    qntg_vertex_if.source o_vertex
);
    import qntg_pkg::*;

    localparam logic signed [32:0] UV_SAT = 33'sd2147483647;
    localparam int SA_W = 1 + 1 + UV_W + POS_PK_W;   // degenerate, last, uv, position
    localparam int SB_W = 1 + UNIT_PK_W + SA_W;      // handedness, normal, SA

    function automatic logic signed [UVC_W-1:0] uv_diff(input logic [UVC_W-1:0] p,
                                                        input logic [UVC_W-1:0] q);
        logic signed [32:0] d;
        d = 33'($signed(p)) - 33'($signed(q));
        if (d > UV_SAT) begin
            d = UV_SAT;
        end else if (d < -UV_SAT) begin
            d = -UV_SAT;
        end
        return d[UVC_W-1:0];
    endfunction

    logic en, accept;

    // sequencer and held quad
    logic       r_busy;
    logic [2:0] r_cnt;
    t_pos       r_qp [4];   // bottom-left, bottom-right, top-left, top-right
    t_uv        r_quv [4];

    // P1: triangle corners and uv differences
    logic signed [POS_W-1:0] n1_a [3], n1_b [3], n1_c [3];
    logic signed [POS_W-1:0] r1_a [3], r1_b [3], r1_c [3];
    t_pos n1_vp, r1_vp;
    t_uv  n1_vuv, r1_vuv;
    logic signed [UVC_W-1:0] n1_ux, n1_uy, n1_vx, n1_vy;
    logic signed [UVC_W-1:0] r1_ux, r1_uy, r1_vx, r1_vy;
    logic r1_last, r1_vld;

    // P2: edges, determinant products
    logic signed [POS_W:0]   r2_x [3], r2_y [3];
    logic signed [POS_W-1:0] r2_vn [3];
    logic signed [63:0]      r2_pd1, r2_pd2;
    logic signed [UVC_W-1:0] r2_ux, r2_uy, r2_vx, r2_vy;
    t_pos r2_vp;
    t_uv  r2_vuv;
    logic r2_last, r2_vld;

    // P3: cross and gradient products
    logic signed [43:0] r3_na [3], r3_nb [3];
    logic signed [53:0] r3_ta [3], r3_tb [3], r3_ba [3], r3_bb [3];
    logic signed [POS_W-1:0] r3_vn [3];
    logic r3_dneg, r3_dzero;
    t_pos r3_vp;
    t_uv  r3_vuv;
    logic r3_last, r3_vld;

    // P4: normalizer lanes
    logic signed [64:0] n3_det;
    logic [3:0][2:0][LANE_W-1:0] n4_lane, r4_lane;
    logic [SA_W-1:0] r4_side;
    logic r4_vld;

    logic [3:0][2:0][UNIT_W-1:0] ua_vec;
    logic [SA_W-1:0] ua_side;
    logic ua_vld;

    // Q1..Q4: orthogonalize and handedness
    logic signed [UNIT_W-1:0] a_tu [3], a_vn [3], a_bu [3];
    logic signed [31:0] r5_dp [3], r5_pa [3], r5_pb [3];
    logic signed [UNIT_W-1:0] r5_tu [3], r5_vn [3], r5_bu [3];
    t_unit r5_nf;
    logic [SA_W-1:0] r5_side;
    logic r5_vld;

    logic signed [33:0] r6_d;
    logic signed [32:0] r6_p [3];
    logic signed [UNIT_W-1:0] r6_tu [3], r6_vn [3], r6_bu [3];
    t_unit r6_nf;
    logic [SA_W-1:0] r6_side;
    logic r6_vld;

    logic signed [49:0] r7_vd [3];
    logic signed [48:0] r7_pb [3];
    logic signed [UNIT_W-1:0] r7_tu [3];
    t_unit r7_nf;
    logic [SA_W-1:0] r7_side;
    logic r7_vld;

    logic signed [51:0] n8_pd;
    logic [0:0][2:0][LANE_W-1:0] n8_lane, r8_lane;
    logic [SB_W-1:0] r8_side;
    logic r8_vld;

    logic [0:0][2:0][UNIT_W-1:0] ub_vec;
    logic [SB_W-1:0] ub_side;
    logic ub_vld;

    // output register
    logic  r_out_vld;
    t_pos  r_out_pos;
    t_unit r_out_nrm;
    t_uv   r_out_uv;
    t_unit r_out_tan;
    logic  r_out_sign, r_out_degen, r_out_last;

    // pipeline advances unless a finished vertex waits
    assign en     = !r_out_vld || o_vertex.ready;
    assign i_quad.ready = en && (!r_busy || r_cnt == VERT_LAST);
    assign accept = i_quad.valid && i_quad.ready;

    // vertex sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= VERT_FIRST;
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= r_busy;
            if (accept) begin
                r_busy <= 1'b1;
                r_cnt  <= VERT_FIRST;
            end else if (r_busy) begin
                if (r_cnt == VERT_LAST) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_qp[0]  <= i_quad.pos_bottom_left;
            r_qp[1]  <= i_quad.pos_bottom_right;
            r_qp[2]  <= i_quad.pos_top_left;
            r_qp[3]  <= i_quad.pos_top_right;
            r_quv[0] <= i_quad.uv_bottom_left;
            r_quv[1] <= i_quad.uv_bottom_right;
            r_quv[2] <= i_quad.uv_top_left;
            r_quv[3] <= i_quad.uv_top_right;
        end
    end

    // P1: pick triangle and vertex for this slot
    always_comb begin
        logic tri2;
        logic [2:0] vj;
        t_pos sa, sb, sc;
        t_uv  u0, u1, u2;
        tri2 = r_cnt >= TRI_SPLIT;
        vj   = tri2 ? r_cnt - TRI_SPLIT : r_cnt;
        sa   = tri2 ? r_qp[1] : r_qp[0];
        sb   = tri2 ? r_qp[3] : r_qp[1];
        sc   = r_qp[2];
        u0   = tri2 ? r_quv[0] : r_quv[2];
        u1   = tri2 ? r_quv[1] : r_quv[0];
        u2   = r_quv[3];
        for (int c = 0; c < 3; c++) begin
            n1_a[c] = $signed(sa[c*POS_W +: POS_W]);
            n1_b[c] = $signed(sb[c*POS_W +: POS_W]);
            n1_c[c] = $signed(sc[c*POS_W +: POS_W]);
        end
        unique case (vj)
            3'd0:    begin n1_vp = sa; n1_vuv = u0; end
            3'd1:    begin n1_vp = sb; n1_vuv = u1; end
            default: begin n1_vp = sc; n1_vuv = u2; end
        endcase
        n1_ux = uv_diff(u1[31:0],  u0[31:0]);
        n1_uy = uv_diff(u1[63:32], u0[63:32]);
        n1_vx = uv_diff(u2[31:0],  u0[31:0]);
        n1_vy = uv_diff(u2[63:32], u0[63:32]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a    <= n1_a;
            r1_b    <= n1_b;
            r1_c    <= n1_c;
            r1_vp   <= n1_vp;
            r1_vuv  <= n1_vuv;
            r1_ux   <= n1_ux;
            r1_uy   <= n1_uy;
            r1_vx   <= n1_vx;
            r1_vy   <= n1_vy;
            r1_last <= r_cnt == VERT_LAST;
        end
    end

    // P2: edges and determinant products
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r2_x[c]  <= (POS_W+1)'(r1_b[c]) - (POS_W+1)'(r1_a[c]);
                r2_y[c]  <= (POS_W+1)'(r1_c[c]) - (POS_W+1)'(r1_a[c]);
                r2_vn[c] <= $signed(r1_vp[c*POS_W +: POS_W]);
            end
            r2_pd1  <= r1_ux * r1_vy;
            r2_pd2  <= r1_uy * r1_vx;
            r2_ux   <= r1_ux;
            r2_uy   <= r1_uy;
            r2_vx   <= r1_vx;
            r2_vy   <= r1_vy;
            r2_vp   <= r1_vp;
            r2_vuv  <= r1_vuv;
            r2_last <= r1_last;
        end
    end

    // P3: normal cross products, uv gradient products, determinant sign
    assign n3_det = 65'(r2_pd1) - 65'(r2_pd2);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_na[0] <= r2_y[1] * r2_x[2];
            r3_nb[0] <= r2_y[2] * r2_x[1];
            r3_na[1] <= r2_y[2] * r2_x[0];
            r3_nb[1] <= r2_y[0] * r2_x[2];
            r3_na[2] <= r2_y[0] * r2_x[1];
            r3_nb[2] <= r2_y[1] * r2_x[0];
            for (int c = 0; c < 3; c++) begin
                r3_ta[c] <= r2_x[c] * r2_vy;
                r3_tb[c] <= r2_y[c] * r2_uy;
                r3_ba[c] <= r2_x[c] * r2_vx;
                r3_bb[c] <= r2_y[c] * r2_ux;
            end
            r3_vn    <= r2_vn;
            r3_dneg  <= n3_det[64];
            r3_dzero <= n3_det == 65'sd0;
            r3_vp    <= r2_vp;
            r3_vuv   <= r2_vuv;
            r3_last  <= r2_last;
        end
    end

    // P4: raw normal, signed tangent and bitangent, vertex position
    always_comb begin
        logic signed [LANE_W-1:0] t, b;
        for (int c = 0; c < 3; c++) begin
            t = LANE_W'(r3_ta[c]) - LANE_W'(r3_tb[c]);
            b = LANE_W'(r3_ba[c]) - LANE_W'(r3_bb[c]);
            if (r3_dneg) begin
                t = -t;
                b = -b;
            end
            n4_lane[0][c] = LANE_W'(r3_na[c]) - LANE_W'(r3_nb[c]);
            n4_lane[1][c] = t;
            n4_lane[2][c] = b;
            n4_lane[3][c] = LANE_W'(r3_vn[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_lane <= n4_lane;
            r4_side <= {r3_dzero, r3_last, r3_vuv, r3_vp};
        end
    end

    // normal, tangent, bitangent and position normalized side by side
    qntg_unitize #(
        .LANES  (4),
        .IN_W   (LANE_W),
        .FRAC   (UNIT_FRAC_BITS),
        .SIDE_W (SA_W)
    ) u_unit_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_vld),
        .i_vec   (r4_lane),
        .i_side  (r4_side),
        .o_valid (ua_vld),
        .o_vec   (ua_vec),
        .o_side  (ua_side)
    );

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            a_tu[c] = $signed(ua_vec[1][c]);
            a_bu[c] = $signed(ua_vec[2][c]);
            a_vn[c] = $signed(ua_vec[3][c]);
        end
    end

    // Q1: dot and cross products of position and tangent
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r5_dp[c] <= a_vn[c] * a_tu[c];
            end
            r5_pa[0] <= a_vn[1] * a_tu[2];
            r5_pb[0] <= a_vn[2] * a_tu[1];
            r5_pa[1] <= a_vn[2] * a_tu[0];
            r5_pb[1] <= a_vn[0] * a_tu[2];
            r5_pa[2] <= a_vn[0] * a_tu[1];
            r5_pb[2] <= a_vn[1] * a_tu[0];
            r5_tu   <= a_tu;
            r5_vn   <= a_vn;
            r5_bu   <= a_bu;
            r5_nf   <= ua_vec[0];
            r5_side <= ua_side;
        end
    end

    // Q2: sums
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_d <= 34'(r5_dp[0]) + 34'(r5_dp[1]) + 34'(r5_dp[2]);
            for (int c = 0; c < 3; c++) begin
                r6_p[c] <= 33'(r5_pa[c]) - 33'(r5_pb[c]);
            end
            r6_tu   <= r5_tu;
            r6_vn   <= r5_vn;
            r6_bu   <= r5_bu;
            r6_nf   <= r5_nf;
            r6_side <= r5_side;
        end
    end

    // Q3: projection and handedness products
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r7_vd[c] <= r6_vn[c] * r6_d;
                r7_pb[c] <= r6_p[c] * r6_bu[c];
            end
            r7_tu   <= r6_tu;
            r7_nf   <= r6_nf;
            r7_side <= r6_side;
        end
    end

    // Q4: Gram-Schmidt residual and handedness sign
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n8_lane[0][c] = (LANE_W'(r7_tu[c]) <<< (2 * UNIT_FRAC_BITS))
                          - LANE_W'(r7_vd[c]);
        end
        n8_pd = 52'(r7_pb[0]) + 52'(r7_pb[1]) + 52'(r7_pb[2]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_lane <= n8_lane;
            r8_side <= {n8_pd[51], r7_nf, r7_side};
        end
    end

    // valid bits of the front and middle stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= ua_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
            r8_vld <= r7_vld;
        end
    end

    // renormalize the orthogonalized tangent
    qntg_unitize #(
        .LANES  (1),
        .IN_W   (LANE_W),
        .FRAC   (UNIT_FRAC_BITS),
        .SIDE_W (SB_W)
    ) u_unit_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_vld),
        .i_vec   (r8_lane),
        .i_side  (r8_side),
        .o_valid (ub_vld),
        .o_vec   (ub_vec),
        .o_side  (ub_side)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= ub_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_pos   <= ub_side[POS_PK_W-1:0];
            r_out_uv    <= ub_side[POS_PK_W +: UV_W];
            r_out_last  <= ub_side[POS_PK_W + UV_W];
            r_out_degen <= ub_side[POS_PK_W + UV_W + 1];
            r_out_nrm   <= ub_side[SA_W +: UNIT_PK_W];
            r_out_tan   <= ub_side[POS_PK_W + UV_W + 1] ? '0 : ub_vec[0];
            r_out_sign  <= !ub_side[POS_PK_W + UV_W + 1] && ub_side[SB_W-1];
        end
    end

    assign o_vertex.valid             = r_out_vld;
    assign o_vertex.vertex_position   = r_out_pos;
    assign o_vertex.vertex_normal     = r_out_nrm;
    assign o_vertex.vertex_uv         = r_out_uv;
    assign o_vertex.tangent_direction = r_out_tan;
    assign o_vertex.tangent_sign      = r_out_sign;
    assign o_vertex.uv_degenerate     = r_out_degen;
    assign o_vertex.last_vertex       = r_out_last;

endmodule
